/* src/somr_pkg.sv */
// ----------------------------------------------------------------------------
// somr_pkg
// Shared types and constants for the spiral order matrix reader.
// ----------------------------------------------------------------------------
package somr_pkg;

  localparam int unsigned MaxRows    = 16;
  localparam int unsigned MaxColumns = 16;
  localparam int unsigned ValueBits  = 16;

  localparam int unsigned StoreDepth = MaxRows * MaxColumns;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned RowW       = $clog2(MaxRows);
  localparam int unsigned ColW       = $clog2(MaxColumns);
  localparam int unsigned CountW     = AddrW + 1;   // holds StoreDepth itself
  localparam int unsigned CfgW       = 5;           // register field width
  localparam int unsigned CfgIdxW    = 2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegRowCount    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegColumnCount = 2'd1;

  // Input function codes
  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncFetch = 1'b1;

  typedef enum logic [3:0] {
    HeadRight = 4'b0001,
    HeadDown  = 4'b0010,
    HeadLeft  = 4'b0100,
    HeadUp    = 4'b1000
  } heading_e;

  // Element store access, one write and one registered read per cycle
  typedef struct packed {
    logic                 we;
    logic [AddrW-1:0]     waddr;
    logic [ValueBits-1:0] wdata;
    logic                 re;
    logic [AddrW-1:0]     raddr;
  } store_req_t;

  // 0 counts as 1, anything above the maximum counts as the maximum
  function automatic logic [CfgW-1:0] clamp_count(input logic [CfgW-1:0] v,
                                                  input logic [CfgW-1:0] maxv);
    logic [CfgW-1:0] r;
    r = v;
    if (v == '0) r = CfgW'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

/* src/somr_store.sv */
// ----------------------------------------------------------------------------
// somr_store
// Element store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module somr_store (
  input  logic                            clk_i,
  input  somr_pkg::store_req_t            req_i,
  output logic [somr_pkg::ValueBits-1:0]  rdata_o
);
  import somr_pkg::*;

  logic [ValueBits-1:0] mem_q [StoreDepth];
  logic [ValueBits-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/spiral_order_matrix_reader.sv */
// ----------------------------------------------------------------------------
// spiral_order_matrix_reader
// Loads a matrix in row-major order and returns it in clockwise spiral order.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a beat is taken on a rising edge with start high and
//   busy low. busy is always low, so one beat can be taken every cycle.
//   func_i = load writes element_value_i at the next row-major slot and
//   gives no result; func_i = fetch gives exactly one result beat.
//   Result channel: done_o is high for one cycle with the result fields;
//   it comes in the cycle after the fetch (the store read is registered).
//   Throughput is one command per cycle, limited by the store's one read
//   and one write port.
//   A fetch before the matrix is fully loaded returns not_ready_o with zero
//   fields. A load into a full matrix starts a new matrix at slot 0.
//   Config: cfg_we_i writes row count (index 0) or column count (index 1)
//   and restarts loading and traversal; write only while idle.
//   Reset: counts and traversal clear, both registers become 1, the store
//   contents stay undefined until loaded. The receiver cannot stall.
// ----------------------------------------------------------------------------
module spiral_order_matrix_reader (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             func_i,
  input  logic [15:0]                      element_value_i,
  input  logic                             cfg_we_i,
  input  logic [somr_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [somr_pkg::CfgW-1:0]        cfg_data_i,
  output logic                             done_o,
  output logic [15:0]                      result_value_o,
  output logic [7:0]                       matrix_position_o,
  output logic                             last_of_spiral_o,
  output logic                             not_ready_o
);
  import somr_pkg::*;

  localparam logic [CfgW-1:0] MaxRowsC = CfgW'(MaxRows);
  localparam logic [CfgW-1:0] MaxColsC = CfgW'(MaxColumns);

  logic [CfgW-1:0]   row_count_q, column_count_q;
  logic [CountW-1:0] loaded_q, loaded_d;
  logic [CountW-1:0] emitted_q, emitted_d;
  logic [RowW-1:0]   row_q, row_d, top_q, top_d, bottom_q, bottom_d;
  logic [ColW-1:0]   col_q, col_d, left_q, left_d, right_q, right_d;
  heading_e          head_q, head_d;

  logic              done_q, last_q, nr_q;
  logic [AddrW-1:0]  pos_q;

  logic [CfgW-1:0]   rows, cols;
  logic [CountW-1:0] total;
  logic              accept, is_fetch, is_load, full;

  // traversal state as seen by this fetch (spiral start takes fresh limits)
  logic [RowW-1:0]   row_e, top_e, bottom_e;
  logic [ColW-1:0]   col_e, left_e, right_e;
  heading_e          head_e;
  logic [CountW-1:0] pos_wide;
  logic [AddrW-1:0]  pos;
  logic              last;

  store_req_t           store_req;
  logic [ValueBits-1:0] store_rdata;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_fetch = accept && (func_i == FuncFetch);
  assign is_load  = accept && (func_i == FuncLoad);

  assign rows  = clamp_count(row_count_q, MaxRowsC);
  assign cols  = clamp_count(column_count_q, MaxColsC);
  assign total = CountW'(rows) * CountW'(cols);
  assign full  = (loaded_q >= total);

  always_comb begin
    if (emitted_q == '0) begin
      row_e    = '0;
      col_e    = '0;
      top_e    = '0;
      left_e   = '0;
      bottom_e = RowW'(rows - CfgW'(1));
      right_e  = ColW'(cols - CfgW'(1));
      head_e   = HeadRight;
    end else begin
      row_e    = row_q;
      col_e    = col_q;
      top_e    = top_q;
      left_e   = left_q;
      bottom_e = bottom_q;
      right_e  = right_q;
      head_e   = head_q;
    end
    pos_wide = CountW'(row_e) * CountW'(cols) + CountW'(col_e);
    pos      = pos_wide[AddrW-1:0];
    last     = ((emitted_q + CountW'(1)) >= total);
  end

  always_comb begin
    loaded_d  = loaded_q;
    emitted_d = emitted_q;
    row_d     = row_q;
    col_d     = col_q;
    top_d     = top_q;
    bottom_d  = bottom_q;
    left_d    = left_q;
    right_d   = right_q;
    head_d    = head_q;
    store_req = '{we: 1'b0, waddr: loaded_q[AddrW-1:0], wdata: element_value_i,
                  re: 1'b0, raddr: pos};

    if (is_load) begin
      store_req.we = 1'b1;
      if (full) begin
        // new matrix: slot 0, traversal restarts
        store_req.waddr = '0;
        loaded_d  = CountW'(1);
        emitted_d = '0;
        row_d     = '0;
        col_d     = '0;
        top_d     = '0;
        bottom_d  = '0;
        left_d    = '0;
        right_d   = '0;
        head_d    = HeadRight;
      end else begin
        loaded_d = loaded_q + CountW'(1);
      end
    end else if (is_fetch && full) begin
      store_req.re = 1'b1;
      if (last) begin
        emitted_d = '0;
        row_d     = '0;
        col_d     = '0;
        top_d     = '0;
        bottom_d  = '0;
        left_d    = '0;
        right_d   = '0;
        head_d    = HeadRight;
      end else begin
        emitted_d = emitted_q + CountW'(1);
        row_d     = row_e;
        col_d     = col_e;
        top_d     = top_e;
        bottom_d  = bottom_e;
        left_d    = left_e;
        right_d   = right_e;
        head_d    = head_e;
        case (head_e)
          HeadRight: begin
            if (col_e < right_e) begin
              col_d = col_e + ColW'(1);
            end else begin
              top_d  = top_e + RowW'(1);
              head_d = HeadDown;
              row_d  = row_e + RowW'(1);
            end
          end
          HeadDown: begin
            if (row_e < bottom_e) begin
              row_d = row_e + RowW'(1);
            end else begin
              if (right_e != '0) right_d = right_e - ColW'(1);
              head_d = HeadLeft;
              if (col_e != '0) col_d = col_e - ColW'(1);
            end
          end
          HeadLeft: begin
            if (col_e > left_e) begin
              col_d = col_e - ColW'(1);
            end else begin
              if (bottom_e != '0) bottom_d = bottom_e - RowW'(1);
              head_d = HeadUp;
              if (row_e != '0) row_d = row_e - RowW'(1);
            end
          end
          default: begin
            if (row_e > top_e) begin
              row_d = row_e - RowW'(1);
            end else begin
              left_d = left_e + ColW'(1);
              head_d = HeadRight;
              col_d  = col_e + ColW'(1);
            end
          end
        endcase
      end
    end

    // config write restarts loading and traversal
    if (cfg_we_i && (cfg_index_i == RegRowCount || cfg_index_i == RegColumnCount)) begin
      loaded_d  = '0;
      emitted_d = '0;
      row_d     = '0;
      col_d     = '0;
      top_d     = '0;
      bottom_d  = '0;
      left_d    = '0;
      right_d   = '0;
      head_d    = HeadRight;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= CfgW'(1);
      column_count_q <= CfgW'(1);
      loaded_q       <= '0;
      emitted_q      <= '0;
      row_q          <= '0;
      col_q          <= '0;
      top_q          <= '0;
      bottom_q       <= '0;
      left_q         <= '0;
      right_q        <= '0;
      head_q         <= HeadRight;
      done_q         <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == RegRowCount)    row_count_q    <= cfg_data_i;
      if (cfg_we_i && cfg_index_i == RegColumnCount) column_count_q <= cfg_data_i;
      loaded_q  <= loaded_d;
      emitted_q <= emitted_d;
      row_q     <= row_d;
      col_q     <= col_d;
      top_q     <= top_d;
      bottom_q  <= bottom_d;
      left_q    <= left_d;
      right_q   <= right_d;
      head_q    <= head_d;
      done_q    <= is_fetch;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (is_fetch) begin
      nr_q   <= !full;
      last_q <= full && last;
      pos_q  <= full ? pos : '0;
    end
  end

  somr_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .rdata_o (store_rdata)
  );

  assign done_o            = done_q;
  assign not_ready_o       = nr_q;
  assign last_of_spiral_o  = last_q;
  assign matrix_position_o = 8'(pos_q);
  assign result_value_o    = nr_q ? 16'd0 : 16'(store_rdata);

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for spiral_order_matrix_reader. Loads matrices of many
// shapes, fetches them back in spiral order and checks every result beat
// against a cycle-free model of the traversal kept in a scoreboard.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import somr_pkg::*;

  // Indexes with no register behind them; writes there must be dropped
  localparam logic [CfgIdxW-1:0] RegSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpare3 = 2'd3;

  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned ItemTarget   = 1050;
  localparam int unsigned SettleCycles = 3;
  localparam int unsigned MaxReports   = 10;

  typedef enum int unsigned {
    PlanWellFormed,
    PlanReload,
    PlanBroken,
    PlanNoise
  } plan_e;

  typedef struct packed {
    logic [ValueBits-1:0] value;
    logic [7:0]           position;
    logic                 last;
    logic                 not_ready;
  } spiral_beat_t;

  class spiral_scoreboard;
    logic [ValueBits-1:0] matrix_mem [StoreDepth];
    logic [CfgW-1:0]      row_reg;
    logic [CfgW-1:0]      col_reg;
    int unsigned          fill_level;
    int unsigned          served;
    int unsigned          cur_row;
    int unsigned          cur_col;
    int unsigned          top_lim;
    int unsigned          bot_lim;
    int unsigned          left_lim;
    int unsigned          right_lim;
    heading_e             dir;
    spiral_beat_t         awaited_beats [$];
    int unsigned          mismatches;

    function new();
      foreach (matrix_mem[i]) matrix_mem[i] = '0;
      row_reg    = CfgW'(1);
      col_reg    = CfgW'(1);
      fill_level = 0;
      mismatches = 0;
      restart_spiral();
    endfunction

    function int unsigned span(logic [CfgW-1:0] v, int unsigned maxv);
      if (v == '0) return 1;
      if (v > maxv) return maxv;
      return 32'(v);
    endfunction

    function int unsigned matrix_size();
      return span(row_reg, MaxRows) * span(col_reg, MaxColumns);
    endfunction

    function int unsigned pending();
      return awaited_beats.size();
    endfunction

    function void restart_spiral();
      cur_row   = 0;
      cur_col   = 0;
      top_lim   = 0;
      bot_lim   = 0;
      left_lim  = 0;
      right_lim = 0;
      dir       = HeadRight;
      served    = 0;
    endfunction

    function void note_config(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      if (idx == RegRowCount) row_reg = data;
      else if (idx == RegColumnCount) col_reg = data;
      else return;
      fill_level = 0;
      restart_spiral();
    endfunction

    // Move one step along the current ring, turning at the ring limits
    function void step_spiral();
      case (dir)
        HeadRight: begin
          if (cur_col < right_lim) cur_col++;
          else begin
            top_lim++;
            dir = HeadDown;
            cur_row++;
          end
        end
        HeadDown: begin
          if (cur_row < bot_lim) cur_row++;
          else begin
            if (right_lim > 0) right_lim--;
            dir = HeadLeft;
            if (cur_col > 0) cur_col--;
          end
        end
        HeadLeft: begin
          if (cur_col > left_lim) cur_col--;
          else begin
            if (bot_lim > 0) bot_lim--;
            dir = HeadUp;
            if (cur_row > 0) cur_row--;
          end
        end
        default: begin
          if (cur_row > top_lim) cur_row--;
          else begin
            left_lim++;
            dir = HeadRight;
            cur_col++;
          end
        end
      endcase
    endfunction

    function void note_command(logic func, logic [ValueBits-1:0] data);
      int unsigned  cols;
      int unsigned  total;
      int unsigned  at;
      spiral_beat_t beat;
      cols  = span(col_reg, MaxColumns);
      total = matrix_size();
      if (func == FuncLoad) begin
        // a load after a full matrix opens a new one
        if (fill_level >= total) begin
          fill_level = 0;
          restart_spiral();
        end
        matrix_mem[fill_level] = data;
        fill_level++;
        return;
      end
      beat = '0;
      if (fill_level < total) begin
        beat.not_ready = 1'b1;
        awaited_beats = {awaited_beats, beat};
        return;
      end
      if (served == 0) begin
        cur_row   = 0;
        cur_col   = 0;
        dir       = HeadRight;
        top_lim   = 0;
        left_lim  = 0;
        bot_lim   = span(row_reg, MaxRows) - 1;
        right_lim = cols - 1;
      end
      at            = cur_row * cols + cur_col;
      beat.value    = matrix_mem[at];
      beat.position = at[7:0];
      served++;
      if (served >= total) begin
        beat.last = 1'b1;
        restart_spiral();
      end else begin
        step_spiral();
      end
      awaited_beats = {awaited_beats, beat};
    endfunction

    function void check_result(logic [ValueBits-1:0] value, logic [7:0] position,
                               logic last, logic not_ready);
      spiral_beat_t want;
      if (awaited_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result beat: value=%h pos=%0d last=%b not_ready=%b",
                   value, position, last, not_ready);
        return;
      end
      want = awaited_beats.pop_front();
      if (value !== want.value || position !== want.position ||
          last !== want.last || not_ready !== want.not_ready) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("mismatch: expected value=%h pos=%0d last=%b not_ready=%b",
                   want.value, want.position, want.last, want.not_ready);
          $display("          got      value=%h pos=%0d last=%b not_ready=%b",
                   value, position, last, not_ready);
        end
      end
    endfunction
  endclass

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 start           = 1'b0;
  logic                 busy;
  logic                 func_i          = FuncLoad;
  logic [15:0]          element_value_i = '0;
  logic                 cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i     = RegRowCount;
  logic [CfgW-1:0]      cfg_data_i      = '0;
  logic                 done_o;
  logic [15:0]          result_value_o;
  logic [7:0]           matrix_position_o;
  logic                 last_of_spiral_o;
  logic                 not_ready_o;

  spiral_scoreboard sb;
  int unsigned      quiet_cycles = 0;
  int unsigned      items_sent   = 0;
  int unsigned      burst_left   = 0;

  spiral_order_matrix_reader u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .func_i            (func_i),
    .element_value_i   (element_value_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .done_o            (done_o),
    .result_value_o    (result_value_o),
    .matrix_position_o (matrix_position_o),
    .last_of_spiral_o  (last_of_spiral_o),
    .not_ready_o       (not_ready_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result beats are checked before the command beat of the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o)
        sb.check_result(result_value_o, matrix_position_o, last_of_spiral_o, not_ready_o);
      if (cfg_we_i) sb.note_config(cfg_index_i, cfg_data_i);
      if (start && !busy) sb.note_command(func_i, element_value_i);
    end
    if (done_o === 1'b1 || cfg_we_i || (start && busy === 1'b0)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("watchdog: no beat for %0d cycles", QuietLimit);
    $display("status: fail");
    $finish;
  end

  function automatic logic [15:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Mostly small shapes; zero and oversize values hit the clamp
  function automatic logic [CfgW-1:0] pick_raw_count();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return CfgW'($urandom_range(17, 31));
      2:       return CfgW'(16);
      3, 4:    return CfgW'($urandom_range(6, 15));
      default: return CfgW'($urandom_range(1, 5));
    endcase
  endfunction

  function automatic plan_e pick_plan();
    case ($urandom_range(0, 9))
      7:       return PlanReload;
      8:       return PlanBroken;
      9:       return PlanNoise;
      default: return PlanWellFormed;
    endcase
  endfunction

  task automatic pause_sender(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_beat(input logic func, input logic [15:0] data);
    start           <= 1'b1;
    func_i          <= func;
    element_value_i <= data;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      pause_sender($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 9) < 2) ? $urandom_range(50, 150)
                                              : $urandom_range(1, 12);
    end
  endtask

  task automatic load_run(input int unsigned n);
    repeat (n) send_beat(FuncLoad, rand_value());
  endtask

  task automatic fetch_run(input int unsigned n);
    repeat (n) send_beat(FuncFetch, 16'($urandom()));
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Loads give no result beat, so allow the pipeline to empty as well
  task automatic wait_quiet();
    drain();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [CfgW-1:0] rows_raw, input logic [CfgW-1:0] cols_raw,
                           input logic both);
    wait_quiet();
    if ($urandom_range(0, 4) == 0)
      write_reg(($urandom_range(0, 1) != 0) ? RegSpare2 : RegSpare3, CfgW'($urandom()));
    case (both ? 2 : $urandom_range(0, 3))
      0: write_reg(RegRowCount, rows_raw);
      1: write_reg(RegColumnCount, cols_raw);
      2: begin
        write_reg(RegRowCount, rows_raw);
        write_reg(RegColumnCount, cols_raw);
      end
      default: begin
        write_reg(RegColumnCount, cols_raw);
        write_reg(RegRowCount, rows_raw);
      end
    endcase
  endtask

  task automatic exercise_matrix(input plan_e plan);
    int unsigned total;
    int unsigned part;
    total = sb.matrix_size();
    case (plan)
      PlanNoise: begin
        repeat ($urandom_range(5, 30)) send_beat(1'($urandom_range(0, 1)), rand_value());
      end
      PlanBroken: begin
        // early fetches, then a restart by loading past the end
        part = $urandom_range(0, total - 1);
        load_run(part);
        fetch_run($urandom_range(1, 3));
        load_run(total - part);
        fetch_run($urandom_range(1, total));
        load_run($urandom_range(1, 3));
        fetch_run($urandom_range(1, 3));
      end
      PlanReload: begin
        load_run(total);
        fetch_run($urandom_range(1, total));
        load_run(total);
        fetch_run(total);
      end
      default: begin
        load_run(total);
        if ($urandom_range(0, 3) == 0) drain();
        if (total > 64) fetch_run(total + $urandom_range(0, 8));
        else fetch_run(total * $urandom_range(1, 3) + $urandom_range(0, total - 1));
      end
    endcase
  endtask

  task automatic run_directed();
    fetch_run(1);                        // nothing loaded yet
    send_beat(FuncLoad, 16'hFFFF);
    fetch_run(2);                        // 1x1 spiral ends and restarts
    send_beat(FuncLoad, 16'h0000);       // load into a full matrix
    fetch_run(1);
    wait_quiet();
    write_reg(RegSpare2, '1);
    write_reg(RegSpare3, '0);
    fetch_run(1);                        // matrix must survive those writes
    wait_quiet();
    write_reg(RegRowCount, '0);
    write_reg(RegColumnCount, CfgW'(3));
    fetch_run(1);
    send_beat(FuncLoad, 16'h8000);
    fetch_run(1);
    send_beat(FuncLoad, 16'h0001);
    send_beat(FuncLoad, 16'h7FFE);
    fetch_run(4);
    drain();
    send_beat(FuncLoad, 16'h5A5A);
    fetch_run(1);
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    configure(CfgW'(16), CfgW'(16), 1'b1);
    exercise_matrix(PlanWellFormed);
    configure(CfgW'(31), CfgW'(1), 1'b1);
    exercise_matrix(PlanWellFormed);
    configure('0, CfgW'(17), 1'b1);
    exercise_matrix(PlanReload);
    while (items_sent < ItemTarget) begin
      configure(pick_raw_count(), pick_raw_count(), 1'b0);
      exercise_matrix(pick_plan());
    end
    drain();
    repeat (SettleCycles + 1) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

/* spiral_order_matrix_reader.f */
src/somr_pkg.sv
src/somr_store.sv
src/spiral_order_matrix_reader.sv
tb/testbench.sv
